// ===== rtl/core/julia_pkg.sv =====
package julia_pkg;

   localparam int FRAC_BITS_DEF  = 28;
   localparam int COORD_BITS_DEF = 12;

   localparam int WORD_W   = 32;
   localparam int WIDE_W   = 64;
   localparam int COUNT_W  = 10;
   localparam int COLOR_W  = 8;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam int DIV_STEPS = COLOR_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam int REM_W     = COUNT_W + COLOR_W;

   localparam logic [COLOR_W-1:0] BLUE_BASE = 8'd139;
   localparam logic [COLOR_W-1:0] WHITE     = 8'd255;

   localparam logic [31:0]        RST_C_REAL    = 32'd211661357;
   localparam logic [31:0]        RST_C_IMAG    = 32'd0;
   localparam logic [30:0]        RST_ESC_LIM   = 31'd386547057;
   localparam logic [31:0]        RST_ORG_REAL  = 32'hECCC_CCCD;
   localparam logic [31:0]        RST_ORG_IMAG  = 32'hECCC_CCCD;
   localparam logic [30:0]        RST_STEP_REAL = 31'd1431656;
   localparam logic [30:0]        RST_STEP_IMAG = 31'd1840700;
   localparam logic [COUNT_W-1:0] RST_MAX_ITER  = 10'd50;

   typedef enum logic [2:0] {
      CSR_C_REAL,
      CSR_C_IMAG,
      CSR_ESC_LIM,
      CSR_ORG_REAL,
      CSR_ORG_IMAG,
      CSR_STEP_REAL,
      CSR_STEP_IMAG,
      CSR_MAX_ITER
   } julia_csr_type;

   typedef struct packed {
      logic [31:0]        c_real;
      logic [31:0]        c_imag;
      logic [30:0]        escape_limit_sq;
      logic [31:0]        origin_real;
      logic [31:0]        origin_imag;
      logic [30:0]        step_real;
      logic [30:0]        step_imag;
      logic [COUNT_W-1:0] max_iter;
   } julia_cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_TEST,
      ST_DIV,
      ST_FIN
   } julia_state_type;

   typedef struct packed {
      logic load;
      logic update;
      logic div_start;
      logic div_step;
      logic out_load;
   } julia_cmd_type;

   typedef struct packed {
      logic cont;
   } julia_sts_type;

endpackage

// ===== rtl/core/julia_ctrl.sv =====
module julia_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  julia_pkg::julia_sts_type sts,
   output julia_pkg::julia_cmd_type cmd
);
   import julia_pkg::*;

   julia_state_type      state_ff, state_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_TEST;
         ST_TEST: begin
            if (sts.cont) begin
               cmd.update = 1'b1;
               state_in   = ST_MUL;
            end else begin
               cmd.div_start = 1'b1;
               div_cnt_in    = '0;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/julia_dp.sv =====
module julia_dp #(
   parameter int FRAC_BITS  = julia_pkg::FRAC_BITS_DEF,
   parameter int COORD_BITS = julia_pkg::COORD_BITS_DEF
) (
   input  logic                            clock,
   input  julia_pkg::julia_cfg_type        cfg,
   input  logic [COORD_BITS-1:0]           pixel_col,
   input  logic [COORD_BITS-1:0]           pixel_row,
   input  julia_pkg::julia_cmd_type        cmd,
   output julia_pkg::julia_sts_type        sts,
   output logic [julia_pkg::COUNT_W-1:0]   iter_count,
   output logic                            inside_res,
   output logic [julia_pkg::COLOR_W-1:0]   red,
   output logic [julia_pkg::COLOR_W-1:0]   green,
   output logic [julia_pkg::COLOR_W-1:0]   blue
);
   import julia_pkg::*;

   localparam int LimShift = WIDE_W - 1 - FRAC_BITS;

   logic signed [WORD_W-1:0] zx_ff, zx_in, zy_ff, zy_in;
   logic signed [WIDE_W-1:0] xx_ff, yy_ff, xy_ff, xy2_ff, diff_ff;
   logic signed [WIDE_W-1:0] xx_in, yy_in, xy_in;
   logic signed [WIDE_W-1:0] diff_sh, xy_sh;
   logic [WIDE_W-1:0]        mag_ff, lim_ext, lim;
   logic                     lim_sat;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic [REM_W-1:0]         rem_ff, rem_in, dsh_ff, dsh_in;
   logic [COLOR_W-1:0]       quot_ff, quot_in, bright;
   logic                     in_set;

   // escape limit aligned to the 2*FRAC_BITS fraction of |z|^2, saturating
   always_comb begin
      lim_ext = WIDE_W'(cfg.escape_limit_sq);
      lim_sat = (lim_ext >> LimShift) != '0;
      lim     = lim_sat ? '1 : (lim_ext << FRAC_BITS);
   end

   // start point and iterate
   always_comb begin
      diff_sh = diff_ff >>> FRAC_BITS;
      xy_sh   = xy2_ff >>> (FRAC_BITS - 1);
      zx_in   = zx_ff;
      zy_in   = zy_ff;
      if (cmd.load) begin
         zx_in = $signed(WORD_W'(cfg.origin_real
                 + WORD_W'(pixel_col) * WORD_W'(cfg.step_real)));
         zy_in = $signed(WORD_W'(cfg.origin_imag
                 + WORD_W'(pixel_row) * WORD_W'(cfg.step_imag)));
      end else if (cmd.update) begin
         zx_in = $signed(diff_sh[WORD_W-1:0] + cfg.c_real);
         zy_in = $signed(xy_sh[WORD_W-1:0] + cfg.c_imag);
      end
   end

   always_comb begin
      xx_in = zx_ff * zx_ff;
      yy_in = zy_ff * zy_ff;
      xy_in = zx_ff * zy_ff;
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.load) begin
         count_in = COUNT_W'(1);
      end else if (cmd.update) begin
         count_in = count_ff + 1'b1;
      end
   end

   // restoring division count*255 / max_iter, one quotient bit a cycle
   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      if (cmd.div_start) begin
         rem_in  = {count_ff, COLOR_W'(0)} - REM_W'(count_ff);
         dsh_in  = {1'b0, cfg.max_iter, (COLOR_W - 1)'(0)};
         quot_in = '0;
      end else if (cmd.div_step) begin
         dsh_in = dsh_ff >> 1;
         if (rem_ff >= dsh_ff) begin
            rem_in  = rem_ff - dsh_ff;
            quot_in = {quot_ff[COLOR_W-2:0], 1'b1};
         end else begin
            quot_in = {quot_ff[COLOR_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      zx_ff    <= zx_in;
      zy_ff    <= zy_in;
      xx_ff    <= xx_in;
      yy_ff    <= yy_in;
      xy_ff    <= xy_in;
      mag_ff   <= $unsigned(xx_ff) + $unsigned(yy_ff);
      diff_ff  <= xx_ff - yy_ff;
      xy2_ff   <= xy_ff;
      count_ff <= count_in;
      rem_ff   <= rem_in;
      dsh_ff   <= dsh_in;
      quot_ff  <= quot_in;
   end

   assign sts.cont = (mag_ff < lim) && (count_ff < cfg.max_iter);

   always_comb begin
      in_set = (count_ff == cfg.max_iter);
      bright = (cfg.max_iter == '0) ? '0 : quot_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         iter_count <= count_ff;
         inside_res <= in_set;
         red        <= in_set ? WHITE : bright;
         green      <= in_set ? WHITE : bright;
         blue       <= in_set ? WHITE : COLOR_W'(bright + BLUE_BASE);
      end
   end

endmodule

// ===== rtl/core/julia_escape_time_pixel.sv =====
// Julia set escape-time evaluator for one pixel per request.
//
// Request channel (req_*): a pixel column and row. The pixel maps to the
// start point z = origin + coordinate * step in signed fixed point, and
// z = z^2 + c is iterated until |z|^2 reaches the escape limit or the
// count reaches max_iter.
// Result channel (rsp_*): the final count, the inside flag and an RGB color.
// Configuration (csr_*): APB-style, one 32-bit register per word; write
// registers only while no request is in flight.
// Each iteration steps through square/multiply, sum, then escape test and
// update; a serial divider then forms the brightness. Requests are taken
// one at a time: no new request is accepted until the previous pixel has
// been handed to the output register. The result sits in an output
// register, so a new request is accepted while a result waits; a stalled
// receiver holds the next finished pixel in the final stage and blocks
// further requests until the output frees up.
// Reset clears the controller and restores all configuration registers to defaults.
module julia_escape_time_pixel #(
   parameter int FRAC_BITS  = julia_pkg::FRAC_BITS_DEF,
   parameter int COORD_BITS = julia_pkg::COORD_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [COORD_BITS-1:0]            req_pixel_col,
   input  logic [COORD_BITS-1:0]            req_pixel_row,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [julia_pkg::COUNT_W-1:0]    rsp_iter_count,
   output logic                             rsp_inside_res,
   output logic [julia_pkg::COLOR_W-1:0]    rsp_red,
   output logic [julia_pkg::COLOR_W-1:0]    rsp_green,
   output logic [julia_pkg::COLOR_W-1:0]    rsp_blue,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [julia_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [julia_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [julia_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);
   import julia_pkg::*;

   julia_cfg_type cfg_ff, cfg_in;
   julia_csr_type csr_idx;
   logic          csr_wr;
   julia_cmd_type cmd;
   julia_sts_type sts;

   // configuration registers: word address selects the register
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = julia_csr_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_idx)
            CSR_C_REAL:    cfg_in.c_real          = csr_pwdata;
            CSR_C_IMAG:    cfg_in.c_imag          = csr_pwdata;
            CSR_ESC_LIM:   cfg_in.escape_limit_sq = csr_pwdata[30:0];
            CSR_ORG_REAL:  cfg_in.origin_real     = csr_pwdata;
            CSR_ORG_IMAG:  cfg_in.origin_imag     = csr_pwdata;
            CSR_STEP_REAL: cfg_in.step_real       = csr_pwdata[30:0];
            CSR_STEP_IMAG: cfg_in.step_imag       = csr_pwdata[30:0];
            CSR_MAX_ITER:  cfg_in.max_iter        = csr_pwdata[COUNT_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.c_real          <= RST_C_REAL;
         cfg_ff.c_imag          <= RST_C_IMAG;
         cfg_ff.escape_limit_sq <= RST_ESC_LIM;
         cfg_ff.origin_real     <= RST_ORG_REAL;
         cfg_ff.origin_imag     <= RST_ORG_IMAG;
         cfg_ff.step_real       <= RST_STEP_REAL;
         cfg_ff.step_imag       <= RST_STEP_IMAG;
         cfg_ff.max_iter        <= RST_MAX_ITER;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back: zero-extend the narrow registers
   always_comb begin
      case (csr_idx)
         CSR_C_REAL:    csr_prdata = cfg_ff.c_real;
         CSR_C_IMAG:    csr_prdata = cfg_ff.c_imag;
         CSR_ESC_LIM:   csr_prdata = CSR_DATA_W'(cfg_ff.escape_limit_sq);
         CSR_ORG_REAL:  csr_prdata = cfg_ff.origin_real;
         CSR_ORG_IMAG:  csr_prdata = cfg_ff.origin_imag;
         CSR_STEP_REAL: csr_prdata = CSR_DATA_W'(cfg_ff.step_real);
         CSR_STEP_IMAG: csr_prdata = CSR_DATA_W'(cfg_ff.step_imag);
         CSR_MAX_ITER:  csr_prdata = CSR_DATA_W'(cfg_ff.max_iter);
         default:       csr_prdata = '0;
      endcase
   end

   // sequencing: accept, iterate, divide, hand off to the output register
   julia_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // arithmetic: start point, complex square, escape test, brightness
   julia_dp #(
      .FRAC_BITS  (FRAC_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock      (clock),
      .cfg        (cfg_ff),
      .pixel_col  (req_pixel_col),
      .pixel_row  (req_pixel_row),
      .cmd        (cmd),
      .sts        (sts),
      .iter_count (rsp_iter_count),
      .inside_res (rsp_inside_res),
      .red        (rsp_red),
      .green      (rsp_green),
      .blue       (rsp_blue)
   );

`ifndef ASSERT_OFF
   // an accepted request makes the block busy on the next cycle
   a_busy_after_req : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while iteration still idle");

   // the count starts at one and never wraps
   a_count_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_iter_count != '0))
      else $error("result carries a zero iteration count");

   // points inside the set are white
   a_inside_white : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_inside_res) |->
         (rsp_red == WHITE && rsp_green == WHITE && rsp_blue == WHITE))
      else $error("inside point is not white");

   // escaped points are dark blue plus one shared brightness
   a_escape_color : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_inside_res) |->
         (rsp_red == rsp_green && rsp_blue == COLOR_W'(rsp_red + BLUE_BASE)))
      else $error("escaped point color is inconsistent");
`endif

endmodule

// ===== tb/julia_escape_time_pixel_tb.sv =====
`timescale 1ns / 100ps

typedef logic [julia_pkg::COORD_BITS_DEF-1:0] coord_t;

typedef struct packed {
   logic [julia_pkg::COUNT_W-1:0] iter_count;
   logic                          inside_res;
   logic [julia_pkg::COLOR_W-1:0] red;
   logic [julia_pkg::COLOR_W-1:0] green;
   logic [julia_pkg::COLOR_W-1:0] blue;
} pixel_result_t;

class pixel_scoreboard;
   julia_pkg::julia_cfg_type regs;
   pixel_result_t            pending_pixels[$];
   int unsigned              mismatches;

   function new(julia_pkg::julia_cfg_type start_regs);
      regs       = start_regs;
      mismatches = 0;
   endfunction

   function void set_register(julia_pkg::julia_csr_type idx, logic [31:0] value);
      case (idx)
         julia_pkg::CSR_C_REAL:    regs.c_real          = value;
         julia_pkg::CSR_C_IMAG:    regs.c_imag          = value;
         julia_pkg::CSR_ESC_LIM:   regs.escape_limit_sq = value[30:0];
         julia_pkg::CSR_ORG_REAL:  regs.origin_real     = value;
         julia_pkg::CSR_ORG_IMAG:  regs.origin_imag     = value;
         julia_pkg::CSR_STEP_REAL: regs.step_real       = value[30:0];
         julia_pkg::CSR_STEP_IMAG: regs.step_imag       = value[30:0];
         julia_pkg::CSR_MAX_ITER:  regs.max_iter        = value[julia_pkg::COUNT_W-1:0];
         default: ;
      endcase
   endfunction

   function pixel_result_t escape_time(coord_t col, coord_t row);
      logic [31:0]   zx;
      logic [31:0]   zy;
      logic [63:0]   lim;
      logic [63:0]   ax;
      logic [63:0]   ay;
      logic [63:0]   mag;
      longint        x;
      longint        y;
      longint        diff;
      longint        prod;
      int unsigned   count;
      int unsigned   bright;
      pixel_result_t res;
      zx  = 32'(64'(regs.origin_real) + 64'(col) * 64'(regs.step_real));
      zy  = 32'(64'(regs.origin_imag) + 64'(row) * 64'(regs.step_imag));
      lim = 64'(regs.escape_limit_sq) << julia_pkg::FRAC_BITS_DEF;
      if ((64'(regs.escape_limit_sq) >> (63 - julia_pkg::FRAC_BITS_DEF)) != 0)
         lim = '1;
      count = 1;
      forever begin
         x   = longint'(signed'(zx));
         y   = longint'(signed'(zy));
         ax  = (x < 0) ? 64'(-x) : 64'(x);
         ay  = (y < 0) ? 64'(-y) : 64'(y);
         mag = ax * ax + ay * ay;
         if (!(mag < lim && count < regs.max_iter))
            break;
         diff = x * x - y * y;
         prod = x * y;
         zx   = 32'(diff >>> julia_pkg::FRAC_BITS_DEF) + regs.c_real;
         zy   = 32'(prod >>> (julia_pkg::FRAC_BITS_DEF - 1)) + regs.c_imag;
         count++;
      end
      res.iter_count = 10'(count);
      res.inside_res = (count == regs.max_iter);
      if (res.inside_res) begin
         res.red   = julia_pkg::WHITE;
         res.green = julia_pkg::WHITE;
         res.blue  = julia_pkg::WHITE;
      end else begin
         bright    = (regs.max_iter != 0) ? (count * 255) / regs.max_iter : 0;
         res.red   = 8'(bright);
         res.green = 8'(bright);
         res.blue  = julia_pkg::BLUE_BASE + 8'(bright);
      end
      return res;
   endfunction

   function void note_request(coord_t col, coord_t row);
      pending_pixels.push_back(escape_time(col, row));
   endfunction

   function int pending();
      return pending_pixels.size();
   endfunction

   function void check_result(pixel_result_t got);
      pixel_result_t want;
      if (pending_pixels.size() == 0) begin
         $error("result with no request pending: iter_count %0d", got.iter_count);
         mismatches++;
         return;
      end
      want = pending_pixels.pop_front();
      if (got.iter_count !== want.iter_count) begin
         $error("iter_count: expected %0d, actual %0d", want.iter_count, got.iter_count);
         mismatches++;
      end
      if (got.inside_res !== want.inside_res) begin
         $error("inside_res: expected %0d, actual %0d", want.inside_res, got.inside_res);
         mismatches++;
      end
      if (got.red !== want.red) begin
         $error("red: expected %0d, actual %0d", want.red, got.red);
         mismatches++;
      end
      if (got.green !== want.green) begin
         $error("green: expected %0d, actual %0d", want.green, got.green);
         mismatches++;
      end
      if (got.blue !== want.blue) begin
         $error("blue: expected %0d, actual %0d", want.blue, got.blue);
         mismatches++;
      end
   endfunction
endclass

module julia_escape_time_pixel_tb;
   import julia_pkg::*;

   localparam int RANDOM_REQUESTS = 1430;
   // long receiver hold-off; well past the time the block needs to fill up
   localparam int STALL_CYCLES    = 3000;
   // sized for the slowest request, at the full 1023 iterations, plus the hold-off above
   localparam int WATCHDOG_LIMIT  = 20000;
   localparam int SETTLE_CYCLES   = 60;

   localparam julia_cfg_type DEFAULT_SETTINGS = '{
      c_real:          RST_C_REAL,
      c_imag:          RST_C_IMAG,
      escape_limit_sq: RST_ESC_LIM,
      origin_real:     RST_ORG_REAL,
      origin_imag:     RST_ORG_IMAG,
      step_real:       RST_STEP_REAL,
      step_imag:       RST_STEP_IMAG,
      max_iter:        RST_MAX_ITER
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   coord_t                req_pixel_col;
   coord_t                req_pixel_row;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [COUNT_W-1:0]    rsp_iter_count;
   logic                  rsp_inside_res;
   logic [COLOR_W-1:0]    rsp_red;
   logic [COLOR_W-1:0]    rsp_green;
   logic [COLOR_W-1:0]    rsp_blue;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   pixel_scoreboard sb;
   pixel_result_t   observed;
   bit              no_gaps;       // both sides run flat out while set
   bit              rsp_hold_req;  // ask the receiver for one long hold-off
   int unsigned     quiet_cycles;

   // 12 ns period: 6 ns low, 6 ns high
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   julia_escape_time_pixel uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_col  (req_pixel_col),
      .req_pixel_row  (req_pixel_row),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_iter_count (rsp_iter_count),
      .rsp_inside_res (rsp_inside_res),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   assign observed = {rsp_iter_count, rsp_inside_res, rsp_red, rsp_green, rsp_blue};

   // Check every accepted result against the oldest predicted pixel.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(observed);
   end

   // Watchdog: any handshake on any port counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver: drop ready about a quarter of the cycles; on request, hold it
   // low for a long stretch so the block fills up and stalls its input.
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            stall_left   = STALL_CYCLES;
         end
         if (stall_left != 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready = no_gaps || ($urandom_range(0, 99) >= 25);
         end
      end
   end

   // Offer one pixel request; idle first at random, then hold valid and the
   // payload until the block takes it. Valid stays high afterwards so the
   // next call can chain a request without a gap.
   task automatic send_pixel(coord_t col, coord_t row);
      @(negedge clock);
      while (!no_gaps && $urandom_range(0, 99) < 25) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_pixel_col = col;
      req_pixel_row = row;
      do @(posedge clock); while (!req_ready);
      sb.note_request(col, row);
   endtask

   // Drop valid and wait until every predicted pixel has come back.
   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle; the register takes the
   // data at the edge where psel, penable, pwrite and pready are all high.
   task automatic write_csr(julia_csr_type idx, logic [31:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_register(idx, value);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // Reprogram every register once the block is idle. Unused upper data
   // bits get random junk, which the block must ignore.
   task automatic load_settings(julia_cfg_type s);
      drain_results();
      write_csr(CSR_C_REAL,    s.c_real);
      write_csr(CSR_C_IMAG,    s.c_imag);
      write_csr(CSR_ESC_LIM,   {1'($urandom), s.escape_limit_sq});
      write_csr(CSR_ORG_REAL,  s.origin_real);
      write_csr(CSR_ORG_IMAG,  s.origin_imag);
      write_csr(CSR_STEP_REAL, {1'($urandom), s.step_real});
      write_csr(CSR_STEP_IMAG, {1'($urandom), s.step_imag});
      write_csr(CSR_MAX_ITER,  {22'($urandom), s.max_iter});
   endtask

   // Mostly a window over the interesting part of the plane with c inside
   // the unit square; now and then fully random values that wrap.
   function automatic julia_cfg_type random_settings(bit slow);
      julia_cfg_type s;
      s = DEFAULT_SETTINGS;
      if ($urandom_range(0, 9) < 7) begin
         s.c_real = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
         s.c_imag = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
      end else begin
         s.c_real = $urandom;
         s.c_imag = $urandom;
      end
      case ($urandom_range(0, 7))
         0, 1:    s.escape_limit_sq = 31'($urandom);
         2:       s.escape_limit_sq = 31'($urandom_range(0, 32'h1000_0000));
         default: s.escape_limit_sq = 31'h4000_0000;  // radius 2
      endcase
      if ($urandom_range(0, 9) < 7) begin
         s.origin_real = 32'd0 - $urandom_range(32'h1000_0000, 32'h2000_0000);
         s.origin_imag = 32'd0 - $urandom_range(32'h1000_0000, 32'h2000_0000);
         s.step_real   = 31'($urandom_range(32'h0002_0000, 32'h0004_0000));
         s.step_imag   = 31'($urandom_range(32'h0002_0000, 32'h0004_0000));
      end else begin
         s.origin_real = $urandom;
         s.origin_imag = $urandom;
         s.step_real   = 31'($urandom);
         s.step_imag   = 31'($urandom);
      end
      s.max_iter = slow ? 10'($urandom_range(200, 1023)) : 10'($urandom_range(2, 64));
      return s;
   endfunction

   // Favor the edges of the pixel grid a little.
   function automatic coord_t pick_coord();
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return '1;
         default: return coord_t'($urandom);
      endcase
   endfunction

   initial begin
      julia_cfg_type s;
      int unsigned   phase;
      int unsigned   n_phase;
      int unsigned   sent;
      int unsigned   i;
      bit            slow;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_pixel_col = '0;
      req_pixel_row = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      no_gaps       = 1'b0;
      rsp_hold_req  = 1'b0;
      quiet_cycles  = 0;
      sb            = new(DEFAULT_SETTINGS);
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset settings: grid corners, center and alternating bit patterns.
      send_pixel('0, '0);
      send_pixel('1, '1);
      send_pixel('0, '1);
      send_pixel('1, '0);
      send_pixel(12'd2048, 12'd2048);
      send_pixel(12'hAAA, 12'h555);

      // Iteration limit of zero: count 1, not inside, plain dark blue.
      s = DEFAULT_SETTINGS;
      s.max_iter = 10'd0;
      load_settings(s);
      send_pixel(12'd1000, 12'd1200);
      send_pixel('1, '1);

      // Iteration limit of one: loop never runs, yet the pixel is inside.
      s.max_iter = 10'd1;
      load_settings(s);
      send_pixel(12'd2048, 12'd2048);

      // Smallest regular limit.
      s.max_iter = 10'd2;
      load_settings(s);
      send_pixel(12'd2048, 12'd2048);

      // Zero escape limit: every point escapes at once.
      s.max_iter        = 10'd50;
      s.escape_limit_sq = '0;
      load_settings(s);
      send_pixel(12'h123, 12'h321);

      // Largest escape limit with c at the edges: iterates wrap around.
      s.escape_limit_sq = '1;
      s.c_real          = 32'h7FFF_FFFF;
      s.c_imag          = 32'h8000_0000;
      s.max_iter        = 10'd20;
      load_settings(s);
      send_pixel('0, '0);
      send_pixel('1, '1);

      // Start point wraps: extreme origin with the largest step.
      s = DEFAULT_SETTINGS;
      s.origin_real = 32'h7FFF_FFFF;
      s.origin_imag = 32'h8000_0000;
      s.step_real   = '1;
      s.step_imag   = '1;
      s.max_iter    = 10'd10;
      load_settings(s);
      send_pixel('1, '1);
      send_pixel(12'd1, 12'd1);

      // c at the opposite extremes.
      s.c_real          = 32'h8000_0000;
      s.c_imag          = 32'h7FFF_FFFF;
      s.escape_limit_sq = '1;
      s.max_iter        = 10'd30;
      load_settings(s);
      send_pixel(12'd77, 12'd3000);
      send_pixel(12'd4000, 12'd5);

      // z pinned at zero with the largest limit: the full 1023 iterations.
      s = DEFAULT_SETTINGS;
      s.c_real      = '0;
      s.c_imag      = '0;
      s.origin_real = '0;
      s.origin_imag = '0;
      s.step_real   = '0;
      s.step_imag   = '0;
      s.max_iter    = 10'd1023;
      load_settings(s);
      send_pixel(12'd9, 12'd9);

      // Random phases; a few use large limits with only a handful of pixels.
      phase = 0;
      sent  = 0;
      while (sent < RANDOM_REQUESTS) begin
         slow = (phase == 1) || (phase % 9 == 5);
         s    = random_settings(slow);
         if (phase == 0)
            s.max_iter = 10'd2;
         if (phase == 1)
            s.max_iter = 10'd1023;
         load_settings(s);
         no_gaps = (phase == 3);
         n_phase = slow ? 10 : 70;
         for (i = 0; i < n_phase; i++) begin
            // keep offering requests while the receiver holds off
            if (phase == 4 && i == 20)
               rsp_hold_req = 1'b1;
            // pause the sender until everything is back, mid-phase
            if (phase == 6 && i == 35)
               drain_results();
            send_pixel(pick_coord(), pick_coord());
         end
         sent += n_phase;
         phase++;
      end

      no_gaps = 1'b0;
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
